// ----- src/midpoint_subdivision_line_clipper_defines.svh -----
// Assertion macros for the line clipper checker.
`ifndef MIDPOINT_SUBDIVISION_LINE_CLIPPER_DEFINES_SVH
`define MIDPOINT_SUBDIVISION_LINE_CLIPPER_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CLU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("clipper check failed");

// next-cycle implication, sampled on aclk, off during reset
`define CLU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("clipper check failed");

`endif

// ----- src/clu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types and constants of the midpoint subdivision line clipper.
// ----------------------------------------------------------------------------
package clu_pkg;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;

    localparam int WIN_LEFT_RST   = 0;
    localparam int WIN_TOP_RST    = 0;
    localparam int WIN_RIGHT_RST  = 639;
    localparam int WIN_BOTTOM_RST = 479;

    // outcode bit positions
    localparam int OC_TOP    = 0;
    localparam int OC_BOTTOM = 1;
    localparam int OC_RIGHT  = 2;
    localparam int OC_LEFT   = 3;

    typedef struct packed {
        logic all_in;   // both outcodes zero
        logic reject;   // outcodes share a set bit
    } eval_status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_LOAD   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage
`default_nettype wire

// ----- src/midpoint_subdivision_line_clipper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Flow: each split stays in EVAL; a leaf with entries left on the stack pops one through
// LOAD (registered RAM read); the final leaf goes to FINISH, which loads the last result,
// then IDLE takes the next item. Leaves are pieces plus rejected or dropped halves.
// A result that waits on m_ready stalls EVAL and FINISH.
// Reset (aresetn low, synchronous): idle, stack pointer and counters cleared, window
// registers back to 0/0/639/479. Stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// midpoint_subdivision_line_clipper
// Clips segments to a window by recursive midpoint subdivision on a RAM stack.
// ----------------------------------------------------------------------------
module midpoint_subdivision_line_clipper #(
    parameter int COORD_BITS  = 12,
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_we,
    input  wire logic        [clu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic signed [COORD_BITS-1:0]        cfg_wdata,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [COORD_BITS-1:0]        s_start_x,
    input  wire logic signed [COORD_BITS-1:0]        s_start_y,
    input  wire logic signed [COORD_BITS-1:0]        s_end_x,
    input  wire logic signed [COORD_BITS-1:0]        s_end_y,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed      [COORD_BITS-1:0]        m_piece_start_x,
    output logic signed      [COORD_BITS-1:0]        m_piece_start_y,
    output logic signed      [COORD_BITS-1:0]        m_piece_end_x,
    output logic signed      [COORD_BITS-1:0]        m_piece_end_y,
    output logic                                     m_piece_valid,
    output logic                                     m_last_piece
);

    localparam int CB  = COORD_BITS;
    localparam int SW  = 4 * COORD_BITS;
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int CW  = clu_pkg::CNT_W;

    clu_pkg::state_t state_reg;

    logic signed [CB-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;

    logic [SW-1:0]  cur_reg;
    logic [SW-1:0]  held_reg;
    logic           held_valid_reg;
    logic [SPW-1:0] sp_reg;
    logic [CW-1:0]  count_reg;

    logic           m_valid_reg;
    logic [SW-1:0]  m_seg_reg;
    logic           m_piece_valid_reg;
    logic           m_last_reg;

    clu_pkg::eval_status_t status;
    logic [SW-1:0] first_seg, second_seg, rd_seg;

    logic           out_free;
    logic           out_load;
    logic           has_room;
    logic           ram_we, ram_re;
    logic [SPW-1:0] ram_raddr;

    assign out_free = !m_valid_reg || m_ready;
    assign has_room = ({1'b0, sp_reg} + (SPW+1)'(2)) <= (SPW+1)'(STACK_DEPTH);
    assign ram_raddr = sp_reg - SPW'(1);

    // output register takes a result: a held piece pushed out by a newer one, or the last
    assign out_load = out_free
                      && (((state_reg == clu_pkg::ST_EVAL) && status.all_in && held_valid_reg)
                          || (state_reg == clu_pkg::ST_FINISH));

    clu_seg_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .seg_i      (cur_reg),
        .win_left   (win_left_reg),
        .win_top    (win_top_reg),
        .win_right  (win_right_reg),
        .win_bottom (win_bottom_reg),
        .status_o   (status),
        .first_o    (first_seg),
        .second_o   (second_seg)
    );

    clu_stack_ram #(
        .WIDTH (SW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (sp_reg),
        .wdata (second_seg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_seg)
    );

    // push on a split with room; pop on reject, dropped split, or a taken piece
    always_comb begin
        ram_we = 1'b0;
        ram_re = 1'b0;
        if (state_reg == clu_pkg::ST_EVAL) begin
            if (status.all_in) begin
                ram_re = (!held_valid_reg || out_free) && (sp_reg != '0)
                         && (count_reg != CW'(clu_pkg::MAX_RESULTS - 1));
            end else if (!status.reject && has_room) begin
                ram_we = 1'b1;
            end else begin
                ram_re = (sp_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= CB'(clu_pkg::WIN_LEFT_RST);
            win_top_reg    <= CB'(clu_pkg::WIN_TOP_RST);
            win_right_reg  <= CB'(clu_pkg::WIN_RIGHT_RST);
            win_bottom_reg <= CB'(clu_pkg::WIN_BOTTOM_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                clu_pkg::REG_WIN_LEFT:   win_left_reg   <= cfg_wdata;
                clu_pkg::REG_WIN_TOP:    win_top_reg    <= cfg_wdata;
                clu_pkg::REG_WIN_RIGHT:  win_right_reg  <= cfg_wdata;
                clu_pkg::REG_WIN_BOTTOM: win_bottom_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= clu_pkg::ST_IDLE;
            held_valid_reg <= 1'b0;
            sp_reg         <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                clu_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        cur_reg        <= {s_end_y, s_end_x, s_start_y, s_start_x};
                        sp_reg         <= '0;
                        count_reg      <= '0;
                        held_valid_reg <= 1'b0;
                        state_reg      <= clu_pkg::ST_EVAL;
                    end
                end
                clu_pkg::ST_EVAL: begin
                    if (status.all_in) begin
                        // previous piece is known not to be last once a new one shows up
                        if (!held_valid_reg || out_free) begin
                            if (held_valid_reg) begin
                                m_seg_reg         <= held_reg;
                                m_piece_valid_reg <= 1'b1;
                                m_last_reg        <= 1'b0;
                            end
                            held_reg       <= cur_reg;
                            held_valid_reg <= 1'b1;
                            count_reg      <= count_reg + CW'(1);
                            if (count_reg == CW'(clu_pkg::MAX_RESULTS - 1) || sp_reg == '0) begin
                                state_reg <= clu_pkg::ST_FINISH;
                            end else begin
                                sp_reg    <= sp_reg - SPW'(1);
                                state_reg <= clu_pkg::ST_LOAD;
                            end
                        end
                    end else if (!status.reject && has_room) begin
                        // second half goes to the stack, first half is handled next
                        sp_reg  <= sp_reg + SPW'(1);
                        cur_reg <= first_seg;
                    end else if (sp_reg == '0) begin
                        state_reg <= clu_pkg::ST_FINISH;
                    end else begin
                        sp_reg    <= sp_reg - SPW'(1);
                        state_reg <= clu_pkg::ST_LOAD;
                    end
                end
                clu_pkg::ST_LOAD: begin
                    cur_reg   <= rd_seg;
                    state_reg <= clu_pkg::ST_EVAL;
                end
                clu_pkg::ST_FINISH: begin
                    if (out_free) begin
                        m_seg_reg         <= held_valid_reg ? held_reg : '0;
                        m_piece_valid_reg <= held_valid_reg;
                        m_last_reg        <= 1'b1;
                        held_valid_reg    <= 1'b0;
                        state_reg         <= clu_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= clu_pkg::ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready         = (state_reg == clu_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_piece_start_x = m_seg_reg[0*CB +: CB];
    assign m_piece_start_y = m_seg_reg[1*CB +: CB];
    assign m_piece_end_x   = m_seg_reg[2*CB +: CB];
    assign m_piece_end_y   = m_seg_reg[3*CB +: CB];
    assign m_piece_valid   = m_piece_valid_reg;
    assign m_last_piece    = m_last_reg;

endmodule
`default_nettype wire

// ----- src/clu_stack_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_stack_ram
// Pending-segment stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clu_stack_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/clu_seg_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clu_seg_eval
// Outcode classification and midpoint split of one segment.
// ----------------------------------------------------------------------------
module clu_seg_eval #(
    parameter int COORD_BITS = 12
) (
    input  wire logic        [4*COORD_BITS-1:0] seg_i,
    input  wire logic signed [COORD_BITS-1:0]   win_left,
    input  wire logic signed [COORD_BITS-1:0]   win_top,
    input  wire logic signed [COORD_BITS-1:0]   win_right,
    input  wire logic signed [COORD_BITS-1:0]   win_bottom,
    output clu_pkg::eval_status_t               status_o,
    output logic             [4*COORD_BITS-1:0] first_o,
    output logic             [4*COORD_BITS-1:0] second_o
);

    localparam int CB = COORD_BITS;

    logic signed [CB-1:0] x1, y1, x2, y2;
    logic        [3:0]    code_a, code_b;
    logic signed [CB:0]   dx, dy;
    logic signed [CB:0]   hx, hy;
    logic signed [CB-1:0] mx, my, sx, sy;

    function automatic logic [3:0] outcode(
        input logic signed [CB-1:0] x,
        input logic signed [CB-1:0] y,
        input logic signed [CB-1:0] wl,
        input logic signed [CB-1:0] wt,
        input logic signed [CB-1:0] wr,
        input logic signed [CB-1:0] wb
    );
        logic [3:0] c;
        c = '0;
        c[clu_pkg::OC_TOP]    = (y <= wt);
        c[clu_pkg::OC_BOTTOM] = (y >= wb);
        c[clu_pkg::OC_RIGHT]  = (x >= wr);
        c[clu_pkg::OC_LEFT]   = (x <= wl);
        return c;
    endfunction

    // halve toward zero: bias negatives by one before the arithmetic shift
    function automatic logic signed [CB:0] half(input logic signed [CB:0] d);
        logic signed [CB:0] b;
        b = d + {{CB{1'b0}}, d[CB]};
        return b >>> 1;
    endfunction

    always_comb begin
        x1 = seg_i[0*CB +: CB];
        y1 = seg_i[1*CB +: CB];
        x2 = seg_i[2*CB +: CB];
        y2 = seg_i[3*CB +: CB];

        code_a = outcode(x1, y1, win_left, win_top, win_right, win_bottom);
        code_b = outcode(x2, y2, win_left, win_top, win_right, win_bottom);
        status_o.all_in = ((code_a | code_b) == 4'd0);
        status_o.reject = ((code_a & code_b) != 4'd0);

        dx = {x2[CB-1], x2} - {x1[CB-1], x1};
        dy = {y2[CB-1], y2} - {y1[CB-1], y1};
        hx = half(dx);
        hy = half(dy);
        // midpoint lies between the endpoints, so it fits the coordinate width
        mx = x1 + hx[CB-1:0];
        my = y1 + hy[CB-1:0];

        // step one unit from the midpoint toward the far endpoint
        sx = mx;
        if (dx[CB]) begin
            sx = mx - CB'(1);
        end else if (dx != '0) begin
            sx = mx + CB'(1);
        end
        sy = my;
        if (dy[CB]) begin
            sy = my - CB'(1);
        end else if (dy != '0) begin
            sy = my + CB'(1);
        end

        first_o  = {my, mx, y1, x1};
        second_o = {y2, x2, sy, sx};
    end

endmodule
`default_nettype wire

// ----- src/clu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "midpoint_subdivision_line_clipper_defines.svh"
// ----------------------------------------------------------------------------
// clu_checker
// Port-level checks of the line clipper, bound to the top level.
// ----------------------------------------------------------------------------
module clu_checker #(
    parameter int COORD_BITS = 12
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [COORD_BITS-1:0]         m_piece_start_x,
    input wire logic signed [COORD_BITS-1:0]         m_piece_start_y,
    input wire logic signed [COORD_BITS-1:0]         m_piece_end_x,
    input wire logic signed [COORD_BITS-1:0]         m_piece_end_y,
    input wire logic                                 m_piece_valid,
    input wire logic                                 m_last_piece
);

    logic [4*COORD_BITS-1:0] m_payload;

    assign m_payload = {m_piece_start_x, m_piece_start_y, m_piece_end_x, m_piece_end_y};

    // a stalled result holds its payload
    `CLU_ASSERT_NXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_payload) && $stable(m_piece_valid) && $stable(m_last_piece))

    // an empty result always closes the segment
    `CLU_ASSERT_NOW(a_empty_last, m_valid && !m_piece_valid, m_last_piece)

    // an empty result carries zero coordinates
    `CLU_ASSERT_NOW(a_empty_zero, m_valid && !m_piece_valid, m_payload == '0)

    // one segment at a time: input closes right after an accept
    `CLU_ASSERT_NXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind midpoint_subdivision_line_clipper clu_checker #(
    .COORD_BITS (COORD_BITS)
) u_clu_checker (.*);
`default_nettype wire
